/* hw/rtl/assert_macros.svh */
// Assertion macros included by the interpolator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tsri_pkg.sv */
// Shared types and constants of the sample ring interpolator
package tsri_pkg;
    localparam int TolBits = 20;
    localparam logic [1:0] ModeWrite  = 2'd0;
    localparam logic [1:0] ModeRead   = 2'd1;
    localparam logic [1:0] ModeLookup = 2'd2;
    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StInvalid  = 3'd1;
    localparam logic [2:0] StEmpty    = 3'd2;
    localparam logic [2:0] StFull     = 3'd3;
    localparam logic [2:0] StRange    = 3'd4;
    localparam logic CfgInvalidTime = 1'b0;
    localparam logic CfgTolerance   = 1'b1;
endpackage

/* hw/rtl/tsri_div.sv */
// Iterative restoring divider: floor(num / den), one quotient bit per cycle
module tsri_div import tsri_pkg::*; #(
    parameter int NumBits = 96,
    parameter int DenBits = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NumBits-1:0] i_num,
    input  logic [DenBits-1:0] i_den,
    output logic               o_done,
    output logic [NumBits-1:0] o_quo
);
    localparam int CntBits = $clog2(NumBits + 1);
    logic [NumBits-1:0] r_num;
    logic [DenBits:0]   r_rem;
    logic [DenBits-1:0] r_den;
    logic [CntBits-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DenBits:0]   w_sh;
    logic [DenBits:0]   w_sub;

    assign w_sh  = {r_rem[DenBits-1:0], r_num[NumBits-1]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CntBits'(NumBits);
            end else if (r_busy) begin
                if (!w_sub[DenBits]) begin
                    r_rem <= w_sub;
                    r_num <= {r_num[NumBits-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_num <= {r_num[NumBits-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntBits'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule

/* hw/rtl/timestamped_sample_ring_interpolator_core.sv */
// Top level of the time-sorted sample ring with linear interpolation
// Each command keeps busy high from its accepting edge until its one result word, which
// is strobed on o_valid in the same cycle that busy falls. The receiver cannot stall:
// o_valid is high for that single cycle only. After reset a clearing pass writes every
// slot time to zero before the first command is taken. Every command first reads the
// newest and oldest times and then decides; a rejected command ends there, a write then
// stores its slot and a read fetches the oldest slot. A lookup runs a binary search of
// up to log2(DEPTH)+1 steps and reads the found slot and its neighbor. Interpolation
// then runs three divisions on one shared restoring divider, each after a multiply done
// in two halves.
`include "assert_macros.svh"
module timestamped_sample_ring_interpolator_core import tsri_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int TIME_BITS  = 48,
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic [TIME_BITS-1:0]         i_sample_time,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [((TIME_BITS > TolBits) ? TIME_BITS : TolBits)-1:0] i_cfg_data,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic [TIME_BITS-1:0]         o_out_time,
    output logic signed [COORD_BITS-1:0] o_out_x,
    output logic signed [COORD_BITS-1:0] o_out_y,
    output logic signed [COORD_BITS-1:0] o_out_z,
    output logic                         o_was_interpolated
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = AW + 1;
    localparam int DW = COORD_BITS + 1;
    localparam int NB = DW + TIME_BITS;
    localparam int EW = TIME_BITS + 3 * COORD_BITS;
    localparam int CW = (TIME_BITS > TolBits) ? TIME_BITS : TolBits;
    localparam int HW = (TIME_BITS + 1) / 2;
    localparam int PW = DW + HW;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD_NEW, S_RD_NEW_W, S_RD_OLD, S_RD_OLD_W, S_DEC,
        S_RD_OUT, S_RD_OUT_W, S_WR, S_SRCH, S_SRCH_W, S_SRCH_C, S_HI, S_HI_W,
        S_LO, S_LO_W, S_CHK, S_DIV, S_MUL, S_DIV_W, S_DONE
    } t_state;

    t_state                 r_state;
    logic [EW-1:0]          r_mem [DEPTH];
    logic [EW-1:0]          r_rdata;
    logic [AW-1:0]          r_addr;
    logic [AW-1:0]          r_wp, r_rp;
    logic                   r_may_w, r_may_r;
    logic [TIME_BITS-1:0]   r_inv;
    logic [TolBits-1:0]     r_tol;
    logic [1:0]             r_mode;
    logic [TIME_BITS-1:0]   r_t;
    logic [3*COORD_BITS-1:0] r_pos;
    logic [TIME_BITS-1:0]   r_tmin, r_tmax, r_th, r_tl;
    logic [3*COORD_BITS-1:0] r_ch, r_cl;
    logic [SW-1:0]          r_lo, r_hi, r_off;
    logic [1:0]             r_axis;
    logic                   r_neg;
    logic [COORD_BITS-1:0]  r_res [3];
    logic                   r_dstart;
    logic [NB-1:0]          r_dnum;
    logic [TIME_BITS-1:0]   r_dden;
    logic                   r_valid;
    logic [2:0]             r_status;
    logic [TIME_BITS-1:0]   r_otime;
    logic [COORD_BITS-1:0]  r_ox, r_oy, r_oz;
    logic                   r_interp;

    logic                   w_ddone;
    logic [NB-1:0]          w_quo;
    logic [SW-1:0]          w_mid;
    logic [TIME_BITS-1:0]   w_rtime;
    logic signed [DW-1:0]   w_a, w_b, w_d, w_mag;
    logic [TIME_BITS-1:0]   w_diff;
    logic [COORD_BITS-1:0]  w_step;
    logic [TIME_BITS-1:0]   w_n;
    logic [HW-1:0]          w_nh;
    logic [PW-1:0]          w_pp;

    function automatic logic [AW-1:0] f_wrap(logic [SW-1:0] v);
        return (v >= SW'(DEPTH)) ? AW'(v - SW'(DEPTH)) : AW'(v);
    endfunction

    tsri_div #(.NumBits(NB), .DenBits(TIME_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dnum), .i_den(r_dden), .o_done(w_ddone), .o_quo(w_quo)
    );

    assign w_rtime = r_rdata[EW-1 -: TIME_BITS];
    assign w_mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign w_a     = DW'($signed(r_cl[r_axis*COORD_BITS +: COORD_BITS]));
    assign w_b     = DW'($signed(r_ch[r_axis*COORD_BITS +: COORD_BITS]));
    assign w_d     = w_b - w_a;
    assign w_mag   = w_d[DW-1] ? -w_d : w_d;
    assign w_diff  = (r_th >= r_t) ? r_th - r_t : r_t - r_th;
    assign w_step  = w_quo[COORD_BITS-1:0];
    assign w_n     = r_t - r_tl;
    assign w_nh    = (r_state == S_MUL) ? HW'(w_n >> HW) : w_n[HW-1:0];
    assign w_pp    = PW'($unsigned(w_mag)) * PW'(w_nh);

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR || r_state == S_WR) begin
            r_mem[r_addr] <= (r_state == S_CLEAR) ? '0 : {r_t, r_pos};
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_may_w  <= 1'b1;
            r_may_r  <= 1'b0;
            r_inv    <= '0;
            r_tol    <= TolBits'(1);
            r_valid  <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_dstart <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CfgInvalidTime: r_inv <= i_cfg_data[TIME_BITS-1:0];
                    CfgTolerance:   r_tol <= i_cfg_data[TolBits-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= f_wrap(SW'(r_addr) + 1'b1);
                    if (r_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_mode   <= i_mode;
                        r_t      <= i_sample_time;
                        r_pos    <= {i_pos_x, i_pos_y, i_pos_z};
                        r_status <= StOk;
                        r_otime  <= '0;
                        r_ox     <= '0;
                        r_oy     <= '0;
                        r_oz     <= '0;
                        r_interp <= 1'b0;
                        r_addr   <= f_wrap(SW'(r_wp) + SW'(DEPTH - 1));
                        r_state  <= S_RD_NEW;
                    end
                end
                S_RD_NEW: r_state <= S_RD_NEW_W;
                S_RD_NEW_W: begin
                    r_tmax  <= w_rtime;
                    r_addr  <= r_wp;
                    r_state <= S_RD_OLD;
                end
                S_RD_OLD: r_state <= S_RD_OLD_W;
                S_RD_OLD_W: begin
                    r_tmin  <= w_rtime;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= S_DONE;
                    unique case (r_mode)
                        ModeWrite: begin
                            if (r_t <= r_inv) begin
                                r_status <= StInvalid;
                            end else if (r_wp == r_rp && !r_may_w) begin
                                r_status <= StFull;
                            end else if (r_t <= r_tmax) begin
                                r_status <= StInvalid;
                            end else begin
                                r_addr  <= r_wp;
                                r_state <= S_WR;
                            end
                        end
                        ModeRead: begin
                            if (r_rp == r_wp && !r_may_r) begin
                                r_status <= StEmpty;
                            end else begin
                                r_addr  <= r_rp;
                                r_state <= S_RD_OUT;
                            end
                        end
                        ModeLookup: begin
                            if (r_t <= r_inv) begin
                                r_status <= StInvalid;
                            end else if (r_t < r_tmin || r_t > r_tmax) begin
                                r_status <= StRange;
                            end else if (r_t >= r_tmax) begin
                                r_off   <= SW'(DEPTH - 1);
                                r_state <= S_HI;
                            end else if (r_t <= r_tmin) begin
                                r_off   <= '0;
                                r_state <= S_HI;
                            end else begin
                                r_lo    <= '0;
                                r_hi    <= SW'(DEPTH);
                                r_state <= S_SRCH;
                            end
                        end
                        default: r_status <= StInvalid;
                    endcase
                end
                S_WR: begin
                    r_may_w <= 1'b0;
                    r_may_r <= (f_wrap(SW'(r_wp) + 1'b1) == r_rp);
                    r_wp    <= f_wrap(SW'(r_wp) + 1'b1);
                    r_state <= S_DONE;
                end
                S_RD_OUT: r_state <= S_RD_OUT_W;
                S_RD_OUT_W: begin
                    r_may_r <= 1'b0;
                    r_may_w <= (r_wp == f_wrap(SW'(r_rp) + 1'b1));
                    r_rp    <= f_wrap(SW'(r_rp) + 1'b1);
                    r_otime <= w_rtime;
                    {r_ox, r_oy, r_oz} <= r_rdata[3*COORD_BITS-1:0];
                    r_state <= S_DONE;
                end
                S_SRCH: begin
                    if (r_lo < r_hi) begin
                        r_addr  <= f_wrap(SW'(r_wp) + w_mid);
                        r_state <= S_SRCH_W;
                    end else begin
                        r_off   <= (r_lo >= SW'(DEPTH)) ? SW'(DEPTH - 1) : r_lo;
                        r_state <= S_HI;
                    end
                end
                S_SRCH_W: r_state <= S_SRCH_C;
                S_SRCH_C: begin
                    if (w_rtime < r_t) begin
                        r_lo <= w_mid + 1'b1;
                    end else begin
                        r_hi <= w_mid;
                    end
                    r_state <= S_SRCH;
                end
                S_HI: begin
                    r_addr  <= f_wrap(SW'(r_wp) + r_off);
                    r_state <= S_HI_W;
                end
                S_HI_W: begin
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_th    <= w_rtime;
                    r_ch    <= r_rdata[3*COORD_BITS-1:0];
                    r_addr  <= f_wrap(SW'(r_addr) + SW'(DEPTH - 1));
                    r_state <= S_LO_W;
                end
                S_LO_W: r_state <= S_CHK;
                S_CHK: begin
                    if (CW'(w_diff) <= CW'(r_tol) || r_off == '0
                            || r_th <= w_rtime || r_t <= w_rtime || r_t > r_th) begin
                        r_otime <= r_th;
                        {r_ox, r_oy, r_oz} <= r_ch;
                        r_state <= S_DONE;
                    end else begin
                        r_tl    <= w_rtime;
                        r_cl    <= r_rdata[3*COORD_BITS-1:0];
                        r_axis  <= 2'd2;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_neg    <= w_d[DW-1];
                    r_dnum   <= NB'(w_pp);
                    r_dden   <= r_th - r_tl;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_dnum   <= r_dnum + NB'({w_pp, HW'(0)});
                    r_dstart <= 1'b1;
                    r_state  <= S_DIV_W;
                end
                S_DIV_W: begin
                    if (w_ddone) begin
                        r_res[r_axis] <= r_neg ? w_a[COORD_BITS-1:0] - w_step
                                               : w_a[COORD_BITS-1:0] + w_step;
                        if (r_axis == 2'd0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_axis  <= r_axis - 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DONE: begin
                    if (r_mode == ModeLookup && r_status == StOk && r_state == S_DONE
                            && r_interp == 1'b0 && r_otime == '0) begin
                        r_otime  <= r_t;
                        r_ox     <= r_res[2];
                        r_oy     <= r_res[1];
                        r_oz     <= r_res[0];
                        r_interp <= 1'b1;
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy               = (r_state != S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_out_time         = r_otime;
    assign o_out_x            = r_ox;
    assign o_out_y            = r_oy;
    assign o_out_z            = r_oz;
    assign o_was_interpolated = r_interp;

    `CHK_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "start not taken")
    `CHK_ALWAYS(a_valid_idle, i_clk, i_rst_n, !o_valid || !busy || start, "valid while busy")
    `CHK_ALWAYS(a_interp_ok, i_clk, i_rst_n, !(o_valid && o_was_interpolated) || o_status == StOk,
        "interpolated error")
endmodule

/* verif/timestamped_sample_ring_interpolator_core_tb.sv */
// Testbench for the time-sorted sample ring with linear interpolation
`timescale 1ns / 1ps
module timestamped_sample_ring_interpolator_core_tb;
    import tsri_pkg::*;

    localparam int DEPTH = 64;
    localparam int TIME_BITS = 48;
    localparam int COORD_BITS = 32;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam logic [1:0] ModeUnused = 2'd3;

    typedef struct packed {
        logic [1:0]            mode;
        logic [TIME_BITS-1:0]  t;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } t_cmd;

    typedef struct packed {
        logic [2:0]            status;
        logic [TIME_BITS-1:0]  t;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic                  interp;
    } t_answer;

    // Control words in the command queue: op codes
    localparam logic [2:0] OpCmd   = 3'd0;
    localparam logic [2:0] OpCfg   = 3'd1;
    localparam logic [2:0] OpDrain = 3'd2;
    localparam logic [2:0] OpBurstOff = 3'd3;

    typedef struct {
        logic [2:0] op;
        t_cmd       cmd;
        logic       cfg_index;
        logic [TIME_BITS-1:0] cfg_data;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_mode = '0;
    logic [TIME_BITS-1:0] i_sample_time = '0;
    logic signed [COORD_BITS-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [TIME_BITS-1:0] i_cfg_data = '0;
    logic o_valid;
    logic [2:0] o_status;
    logic [TIME_BITS-1:0] o_out_time;
    logic signed [COORD_BITS-1:0] o_out_x, o_out_y, o_out_z;
    logic o_was_interpolated;

    timestamped_sample_ring_interpolator_core i_dut (.*);

    // predictor state
    logic [TIME_BITS-1:0]  ring_t [DEPTH];
    logic [COORD_BITS-1:0] ring_x [DEPTH], ring_y [DEPTH], ring_z [DEPTH];
    int unsigned wr_ptr, rd_ptr;
    bit can_write, can_read;
    logic [TIME_BITS-1:0] invalid_t;
    logic [19:0] tolerance;

    t_word pending[$];
    t_answer expected_answers[$];
    int errors = 0;
    longint cycles = 0;
    bit stim_done = 0;
    bit no_gaps = 0;
    int gap_left = 0;
    logic [TIME_BITS-1:0] last_t;

    function automatic logic [COORD_BITS-1:0] interp_coord(logic [COORD_BITS-1:0] lo,
            logic [COORD_BITS-1:0] hi, logic [TIME_BITS-1:0] num,
            logic [TIME_BITS-1:0] den);
        logic signed [COORD_BITS:0] a, b, d;
        logic [127:0] prod;
        logic [127:0] q;
        a = $signed(lo);
        b = $signed(hi);
        d = (b >= a) ? b - a : a - b;
        prod = 128'(unsigned'(d)) * 128'(num);
        q = prod / 128'(den);
        if (b >= a) return lo + q[COORD_BITS-1:0];
        return lo - q[COORD_BITS-1:0];
    endfunction

    function automatic t_answer slot_answer(int unsigned s);
        t_answer r;
        r = '0;
        r.t = ring_t[s];
        r.x = ring_x[s];
        r.y = ring_y[s];
        r.z = ring_z[s];
        return r;
    endfunction

    function automatic t_answer ring_step(t_cmd c);
        t_answer r;
        int unsigned wp, rp, newest, off, s, sl, lo, hi, mid;
        logic [TIME_BITS-1:0] tmin, tmax, th, tl, diff;
        r = '0;
        wp = wr_ptr;
        rp = rd_ptr;
        newest = (wp + DEPTH - 1) % DEPTH;
        case (c.mode)
            ModeWrite: begin
                if (c.t <= invalid_t) r.status = StInvalid;
                else if (wp == rp && !can_write) r.status = StFull;
                else if (c.t <= ring_t[newest]) r.status = StInvalid;
                else begin
                    can_write = 0;
                    can_read = ((wp + 1) % DEPTH == rp);
                    ring_t[wp] = c.t;
                    ring_x[wp] = c.x;
                    ring_y[wp] = c.y;
                    ring_z[wp] = c.z;
                    wr_ptr = (wp + 1) % DEPTH;
                end
            end
            ModeRead: begin
                if (rp == wp && !can_read) r.status = StEmpty;
                else begin
                    can_read = 0;
                    can_write = (wp == (rp + 1) % DEPTH);
                    r = slot_answer(rp);
                    rd_ptr = (rp + 1) % DEPTH;
                end
            end
            ModeLookup: begin
                tmin = ring_t[wp];
                tmax = ring_t[newest];
                if (c.t <= invalid_t) r.status = StInvalid;
                else if (c.t < tmin || c.t > tmax) r.status = StRange;
                else begin
                    if (c.t >= tmax) off = DEPTH - 1;
                    else if (c.t <= tmin) off = 0;
                    else begin
                        lo = 0;
                        hi = DEPTH;
                        while (lo < hi) begin
                            mid = lo + (hi - lo) / 2;
                            if (ring_t[(wp + mid) % DEPTH] < c.t) lo = mid + 1;
                            else hi = mid;
                        end
                        off = (lo >= DEPTH) ? DEPTH - 1 : lo;
                    end
                    s = (wp + off) % DEPTH;
                    th = ring_t[s];
                    diff = (th >= c.t) ? th - c.t : c.t - th;
                    sl = (s + DEPTH - 1) % DEPTH;
                    tl = ring_t[sl];
                    if (diff <= tolerance || off == 0 || th <= tl || c.t <= tl || c.t > th)
                        r = slot_answer(s);
                    else begin
                        r.t = c.t;
                        r.x = interp_coord(ring_x[sl], ring_x[s], c.t - tl, th - tl);
                        r.y = interp_coord(ring_y[sl], ring_y[s], c.t - tl, th - tl);
                        r.z = interp_coord(ring_z[sl], ring_z[s], c.t - tl, th - tl);
                        r.interp = 1'b1;
                    end
                end
            end
            default: r.status = StInvalid;
        endcase
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_cmd(logic [1:0] m, logic [TIME_BITS-1:0] t);
        t_word w;
        w.op = OpCmd;
        w.cmd.mode = m;
        w.cmd.t = t;
        w.cmd.x = rand_coord();
        w.cmd.y = rand_coord();
        w.cmd.z = rand_coord();
        w.cfg_index = 1'b0;
        w.cfg_data = '0;
        pending.push_back(w);
    endtask

    task automatic push_cfg(logic idx, logic [TIME_BITS-1:0] d);
        t_word w;
        w.op = OpDrain;
        w.cmd = '0;
        w.cfg_index = idx;
        w.cfg_data = d;
        pending.push_back(w);
        w.op = OpCfg;
        pending.push_back(w);
    endtask

    task automatic push_ctl(logic [2:0] op);
        t_word w;
        w.op = op;
        w.cmd = '0;
        w.cfg_index = 1'b0;
        w.cfg_data = '0;
        pending.push_back(w);
    endtask

    // write sample with a rising time, step shaped for lookups
    task automatic push_rising_write();
        last_t = last_t + $urandom_range(1, ($urandom_range(0, 3) == 0) ? 2000000 : 40);
        push_cmd(ModeWrite, last_t);
    endtask

    task automatic fill_phase(int n);
        logic [TIME_BITS-1:0] base;
        int k;
        base = last_t;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: push_rising_write();
                7, 8, 9: push_cmd(ModeRead, 48'({$urandom, $urandom}));
                10, 11, 12, 13, 14, 15: push_cmd(ModeLookup,
                        base + 48'($urandom_range(0, 32'(last_t - base + 60))) - 30);
                16: push_cmd(ModeWrite, 48'({$urandom, $urandom}));
                17: push_cmd(ModeLookup, 48'({$urandom, $urandom}));
                18: push_cmd(ModeUnused, 48'({$urandom, $urandom}));
                default: push_cmd(ModeWrite, last_t - $urandom_range(0, 3));
            endcase
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stimulus plan
    initial begin
        int k;
        last_t = 48'd1000;
        // directed part
        push_cmd(ModeRead, 0);
        push_cmd(ModeLookup, 48'd5);
        push_cmd(ModeWrite, 48'd0);
        push_cmd(ModeUnused, 48'hffff_ffff_ffff);
        push_cmd(ModeWrite, 48'd100);
        push_cmd(ModeWrite, 48'd100);
        push_cmd(ModeWrite, 48'd300);
        push_cmd(ModeLookup, 48'd99);
        push_cmd(ModeLookup, 48'd100);
        push_cmd(ModeLookup, 48'd101);
        push_cmd(ModeLookup, 48'd200);
        push_cmd(ModeLookup, 48'd300);
        push_cmd(ModeLookup, 48'd301);
        push_cmd(ModeRead, 0);
        push_cmd(ModeRead, 0);
        push_cmd(ModeRead, 0);
        for (k = 0; k < 66; k++) push_rising_write();
        push_cmd(ModeLookup, last_t - 7);
        for (k = 0; k < 65; k++) push_cmd(ModeRead, 0);
        push_ctl(OpDrain);
        // extremes of the registers
        push_cfg(CfgInvalidTime, 48'hffff_ffff_ffff);
        push_cfg(CfgTolerance, 48'd0);
        push_cmd(ModeWrite, 48'hffff_ffff_ffff);
        push_cmd(ModeLookup, 48'hffff_ffff_ffff);
        // random phases over several settings
        for (k = 0; k < 6; k++) begin
            push_cfg(CfgTolerance, (k == 5) ? 48'hf_ffff : 48'($urandom_range(0, 20)));
            push_cfg(CfgInvalidTime, (k == 2) ? 48'd0 : last_t + $urandom_range(0, 50));
            // mix writes, reads and lookups around the newest times
            fill_phase(250);
        end
        push_ctl(OpBurstOff);
        fill_phase(100);
        // newest times at the top of the range
        push_cfg(CfgTolerance, 48'd0);
        push_cfg(CfgInvalidTime, 48'd0);
        push_cmd(ModeWrite, 48'hffff_ffff_fff0);
        push_cmd(ModeWrite, 48'hffff_ffff_ffff);
        push_cmd(ModeLookup, 48'hffff_ffff_fff8);
        for (k = 0; k < 2; k++) push_cmd(ModeRead, 0);
        stim_done = 1;
    end

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_cfg_valid && o_cfg_ready) i_cfg_valid <= 1'b0;
        if (!i_rst_n) begin
        end else if (start) begin
            if (!busy) start <= 1'b0;
        end else if (i_cfg_valid) begin
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
        end else if (pending.size() > 0) begin
            case (pending[0].op)
                OpDrain: begin
                    if (expected_answers.size() == 0 && !busy) begin
                        gap_left <= no_gaps ? 0 : 40;
                        void'(pending.pop_front());
                    end
                end
                OpBurstOff: begin
                    no_gaps = 1;
                    void'(pending.pop_front());
                end
                OpCfg: begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= pending[0].cfg_index;
                    i_cfg_data <= pending[0].cfg_data;
                    if (pending[0].cfg_index == CfgInvalidTime)
                        invalid_t = pending[0].cfg_data;
                    else
                        tolerance = pending[0].cfg_data[19:0];
                    void'(pending.pop_front());
                end
                default: begin
                    if (!no_gaps && $urandom_range(0, 9) == 0) begin
                        gap_left <= $urandom_range(1, 17);
                    end else begin
                        start <= 1'b1;
                        i_mode <= pending[0].cmd.mode;
                        i_sample_time <= pending[0].cmd.t;
                        i_pos_x <= pending[0].cmd.x;
                        i_pos_y <= pending[0].cmd.y;
                        i_pos_z <= pending[0].cmd.z;
                        expected_answers.push_back(ring_step(pending[0].cmd));
                        void'(pending.pop_front());
                    end
                end
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected result status %0d", $time, o_status);
                errors++;
            end else begin
                e = expected_answers.pop_front();
                if (o_status !== e.status || o_out_time !== e.t || o_out_x !== e.x ||
                        o_out_y !== e.y || o_out_z !== e.z ||
                        o_was_interpolated !== e.interp) begin
                    $display("%0t: expected st=%0d t=%h x=%h y=%h z=%h i=%b", $time,
                             e.status, e.t, e.x, e.y, e.z, e.interp);
                    $display("%0t: actual   st=%0d t=%h x=%h y=%h z=%h i=%b", $time,
                             o_status, o_out_time, o_out_x, o_out_y, o_out_z,
                             o_was_interpolated);
                    errors++;
                end
            end
        end
    end

    initial begin
        int k;
        for (k = 0; k < DEPTH; k++) begin
            ring_t[k] = '0;
            ring_x[k] = '0;
            ring_y[k] = '0;
            ring_z[k] = '0;
        end
        wr_ptr = 0;
        rd_ptr = 0;
        can_write = 1;
        can_read = 0;
        invalid_t = '0;
        tolerance = 20'd1;
        forever begin
            @(posedge i_clk);
            if (cycles > CYCLE_LIMIT) begin
                $display("timestamped_sample_ring_interpolator_core_tb failed");
                $finish;
            end
            if (stim_done && pending.size() == 0 && !start && expected_answers.size() == 0)
                break;
        end
        repeat (500) @(posedge i_clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("timestamped_sample_ring_interpolator_core_tb passed");
        else
            $display("timestamped_sample_ring_interpolator_core_tb failed");
        $finish;
    end
endmodule

/* timestamped_sample_ring_interpolator_core.f */
+incdir+hw/rtl
hw/rtl/tsri_pkg.sv
hw/rtl/tsri_div.sv
hw/rtl/timestamped_sample_ring_interpolator_core.sv
verif/timestamped_sample_ring_interpolator_core_tb.sv
